### hdl/rvpg_pkg.sv
package rvpg_pkg;

  localparam int DEFAULT_FRAME_WIDTH  = 1024;
  localparam int DEFAULT_FRAME_HEIGHT = 768;

  localparam int COORD_W   = 10;
  localparam int TIME_W    = 32;
  localparam int CHAN_W    = 8;
  localparam int SIZE_W    = 13;  // holds frame sizes up to 4096
  localparam int RECIP_SH  = 10;  // extra fraction bits of the reciprocal
  localparam int RECIP_W   = 25;
  localparam int QUOT_W    = 25;
  localparam int CORDIC_N  = 16;
  localparam int CORDIC_W  = 24;
  localparam int ANGLE_W   = 24;

  localparam logic [17:0] RADIUS_GAIN = 18'd166886;
  localparam logic [15:0] TIME_GAIN   = 16'd41722;

  // atan(2^-i) in units of 2^-24 turn, rounded.
  function automatic logic [ANGLE_W-1:0] atan_turns(input logic [3:0] i);
    logic [ANGLE_W-1:0] a;
    unique case (i)
      4'd0:  a = 24'd2097152;
      4'd1:  a = 24'd1238021;
      4'd2:  a = 24'd654136;
      4'd3:  a = 24'd332050;
      4'd4:  a = 24'd166669;
      4'd5:  a = 24'd83416;
      4'd6:  a = 24'd41718;
      4'd7:  a = 24'd20860;
      4'd8:  a = 24'd10430;
      4'd9:  a = 24'd5215;
      4'd10: a = 24'd2608;
      4'd11: a = 24'd1304;
      4'd12: a = 24'd652;
      4'd13: a = 24'd326;
      4'd14: a = 24'd163;
      default: a = 24'd81;
    endcase
    return a;
  endfunction

  // Rainbow palette, red in bits 23:16.
  function automatic logic [23:0] palette(input logic [2:0] i);
    logic [23:0] c;
    unique case (i)
      3'd0: c = 24'hFF0000;
      3'd1: c = 24'hFF8000;
      3'd2: c = 24'hFFFF00;
      3'd3: c = 24'h00FF00;
      3'd4: c = 24'h00FFFF;
      3'd5: c = 24'h0000FF;
      3'd6: c = 24'h8000FF;
      default: c = 24'hFF0000;
    endcase
    return c;
  endfunction

endpackage

### hdl/rainbow_vortex_pixel_generator.sv
// Rainbow vortex pixel generator. Each input beat carries one pixel coordinate
// and yields one output beat with its faded rainbow color. The block is a
// 25-stage pipeline and takes one pixel per clock as long as the output is not
// stalled. The depth is set by the two 16-step iterative units, the integer
// square root for the radius and the CORDIC for the angle, each step holding
// one stage. Every stage has its own valid bit and fills empty slots while
// the output waits, so a stalled output beat does not stop intake until the
// pipeline is full. frame_time is written through the cfg port, which is
// always ready; write it only while no pixel is in flight.
module rainbow_vortex_pixel_generator #(
  parameter int FRAME_WIDTH  = rvpg_pkg::DEFAULT_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = rvpg_pkg::DEFAULT_FRAME_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,      // frame_time, unsigned Q16.16 seconds
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,       // [9:0] pixel_x, [19:10] pixel_y, [23:20] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata        // [7:0] red, [15:8] green, [23:16] blue
);

  localparam int NSTAGE = 25;
  localparam int ITER0  = 5;   // first CORDIC / square-root stage
  localparam int P1     = ITER0 + rvpg_pkg::CORDIC_N;
  localparam int P2     = P1 + 1;
  localparam int P3     = P1 + 2;
  localparam int P4     = P1 + 3;

  localparam logic [rvpg_pkg::SIZE_W-1:0] WX = rvpg_pkg::SIZE_W'(FRAME_WIDTH);
  localparam logic [rvpg_pkg::SIZE_W-1:0] WY = rvpg_pkg::SIZE_W'(FRAME_HEIGHT);
  // Truncated reciprocals; the quotient they give is exact or one too small.
  localparam logic [rvpg_pkg::RECIP_W-1:0] RX =
    rvpg_pkg::RECIP_W'((64'd1 << (15 + rvpg_pkg::RECIP_SH)) / FRAME_WIDTH);
  localparam logic [rvpg_pkg::RECIP_W-1:0] RY =
    rvpg_pkg::RECIP_W'((64'd1 << (15 + rvpg_pkg::RECIP_SH)) / FRAME_HEIGHT);

  localparam int QW = rvpg_pkg::QUOT_W;
  localparam int PW = QW + rvpg_pkg::SIZE_W;
  localparam int CW = rvpg_pkg::CORDIC_W;
  localparam int ANGLE_W_L = rvpg_pkg::ANGLE_W;

  logic [31:0]       frame_time;
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_time <= '0;
    end else if (cfg_valid) begin
      frame_time <= cfg_data;
    end
  end

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || m_tready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 0: reciprocal multiply for the coordinate normalization.
  logic [rvpg_pkg::COORD_W-1:0] px0, py0;
  logic [QW-1:0]                qx0, qy0;
  logic [rvpg_pkg::COORD_W+rvpg_pkg::RECIP_W-1:0] prx, pry;

  assign prx = s_tdata[9:0] * RX;
  assign pry = s_tdata[19:10] * RY;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      px0 <= s_tdata[9:0];
      py0 <= s_tdata[19:10];
      qx0 <= QW'(prx >> rvpg_pkg::RECIP_SH);
      qy0 <= QW'(pry >> rvpg_pkg::RECIP_SH);
    end
  end

  // Stage 1: multiply the estimate back by the frame size.
  logic [QW-1:0] qx1, qy1, nnx1, nny1;
  logic [PW-1:0] wx1, wy1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      qx1  <= qx0;
      qy1  <= qy0;
      nnx1 <= {px0, 15'd0};
      nny1 <= {py0, 15'd0};
      wx1  <= qx0 * WX;
      wy1  <= qy0 * WY;
    end
  end

  // Stage 2: correct the quotient, center it and saturate to Q1.15.
  logic [PW-1:0]         rx2, ry2;
  logic [QW-1:0]         qxc, qyc;
  logic signed [QW:0]    cxs, cys;
  logic signed [15:0]    nx2, ny2;

  function automatic logic signed [15:0] sat16(input logic signed [QW:0] v);
    logic signed [15:0] r;
    if (v > (QW+1)'(32767))       r = 16'sd32767;
    else if (v < -(QW+1)'(32768)) r = -16'sd32768;
    else                          r = v[15:0];
    return r;
  endfunction

  always_comb begin
    rx2 = PW'(nnx1) - wx1;
    ry2 = PW'(nny1) - wy1;
    qxc = qx1 + QW'(rx2 >= PW'(WX));
    qyc = qy1 + QW'(ry2 >= PW'(WY));
    cxs = $signed({1'b0, qxc}) - (QW+1)'(16384);
    cys = $signed({1'b0, qyc}) - (QW+1)'(16384);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      nx2 <= sat16(cxs);
      ny2 <= sat16(cys);
    end
  end

  // Stage 3: squares for the radius, CORDIC pre-rotation into the right half plane.
  logic [31:0]          sqx3, sqy3;
  logic signed [CW-1:0] cx3, cy3;
  logic [ANGLE_W_L-1:0] z3;
  logic                 zero3;
  logic signed [CW-1:0] ex, ey;

  assign ex = CW'(nx2) <<< 4;
  assign ey = CW'(ny2) <<< 4;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sqx3  <= 32'(nx2 * nx2);
      sqy3  <= 32'(ny2 * ny2);
      zero3 <= (nx2 == 16'sd0) && (ny2 == 16'sd0);
      if (ex < 0) begin
        cx3 <= -ex;
        cy3 <= -ey;
        z3  <= ANGLE_W_L'(1) << 23;
      end else begin
        cx3 <= ex;
        cy3 <= ey;
        z3  <= '0;
      end
    end
  end

  // Stage 4 writes index 0 of the iteration arrays; step i writes index i+1.
  logic [31:0]          sv [0:rvpg_pkg::CORDIC_N];
  logic [31:0]          sr [0:rvpg_pkg::CORDIC_N];
  logic signed [CW-1:0] cx [0:rvpg_pkg::CORDIC_N];
  logic signed [CW-1:0] cy [0:rvpg_pkg::CORDIC_N];
  logic [ANGLE_W_L-1:0] cz [0:rvpg_pkg::CORDIC_N];
  logic                 cn [0:rvpg_pkg::CORDIC_N];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      sv[0] <= sqx3 + sqy3;
      sr[0] <= '0;
      cx[0] <= cx3;
      cy[0] <= cy3;
      cz[0] <= z3;
      cn[0] <= zero3;
    end
  end

  for (genvar i = 0; i < rvpg_pkg::CORDIC_N; i++) begin : g_iter
    localparam logic [32:0] BIT = 33'd1 << (30 - 2 * i);
    logic [32:0] trial;
    assign trial = {1'b0, sr[i]} + BIT;

    always_ff @(posedge clk) begin
      if (en[ITER0+i]) begin
        // One bit of the integer square root.
        if ({1'b0, sv[i]} >= trial) begin
          sv[i+1] <= sv[i] - trial[31:0];
          sr[i+1] <= (sr[i] >> 1) + BIT[31:0];
        end else begin
          sv[i+1] <= sv[i];
          sr[i+1] <= sr[i] >> 1;
        end
        // One CORDIC vectoring step; the shifts round toward minus infinity.
        if (cy[i] > 0) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + rvpg_pkg::atan_turns(4'(i));
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - rvpg_pkg::atan_turns(4'(i));
        end
        cn[i+1] <= cn[i];
      end
    end
  end

  // P1: radius and time terms in 2^-16 turns, angle and fade.
  logic [15:0] radius;
  logic [33:0] rprod;
  logic [47:0] tprod;
  logic [15:0] rterm1, tterm1, angle1, fade1;

  assign radius = sr[rvpg_pkg::CORDIC_N][15:0];
  assign rprod  = radius * rvpg_pkg::RADIUS_GAIN;
  assign tprod  = frame_time * rvpg_pkg::TIME_GAIN;

  always_ff @(posedge clk) begin
    if (en[P1]) begin
      rterm1 <= rprod[31:16];
      tterm1 <= tprod[31:16];
      angle1 <= cn[rvpg_pkg::CORDIC_N] ? 16'd0 : cz[rvpg_pkg::CORDIC_N][23:8];
      fade1  <= (radius < 16'd32768) ? 16'd32768 - radius : 16'd0;
    end
  end

  // P2: phase wraps in one turn, then splits into segment and fraction.
  logic [15:0] phase;
  logic [18:0] scaled;
  logic [2:0]  seg2;
  logic [15:0] frac2, fade2;

  assign phase  = angle1 + rterm1 - tterm1;
  assign scaled = phase * 3'd7;

  always_ff @(posedge clk) begin
    if (en[P2]) begin
      seg2  <= scaled[18:16];
      frac2 <= scaled[15:0];
      fade2 <= fade1;
    end
  end

  // P3: linear blend between neighboring palette entries.
  logic [23:0] ca, cb;
  logic [16:0] wa;
  logic [7:0]  mix3 [0:2];
  logic [15:0] fade3;

  assign ca = rvpg_pkg::palette(seg2);
  assign cb = rvpg_pkg::palette(seg2 + 3'd1);
  assign wa = 17'h10000 - {1'b0, frac2};

  always_ff @(posedge clk) begin
    if (en[P3]) begin
      for (int c = 0; c < 3; c++) begin
        mix3[c] <= 8'((25'(ca[16-8*c +: 8]) * wa + 25'(cb[16-8*c +: 8]) * frac2) >> 16);
      end
      fade3 <= fade2;
    end
  end

  // P4: fade toward the rim, registered output beat.
  logic [23:0] prod4 [0:2];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod4[c] = mix3[c] * fade3;
    end
  end

  always_ff @(posedge clk) begin
    if (en[P4]) begin
      m_tdata <= {prod4[2][22:15], prod4[1][22:15], prod4[0][22:15]};
    end
  end

endmodule
